// ===== rtl/core/rlfs_pkg.sv =====
package rlfs_pkg;

    localparam int NUM_CHIPS   = 4;
    localparam int MAX_LEDS    = 32;
    localparam int MAX_LEVELS  = 8;
    localparam int MAX_RESULTS = 32;
    localparam int CHIP_W      = 2;
    localparam int LED_W       = 5;
    localparam int CNT_W       = 6;
    localparam int DEPTH       = NUM_CHIPS * MAX_LEDS;
    localparam int ADDR_W      = $clog2(DEPTH);

    localparam logic [2:0] ACT_RANGE  = 3'd0;
    localparam logic [2:0] ACT_COLOR  = 3'd1;
    localparam logic [2:0] ACT_LEVEL  = 3'd2;
    localparam logic [2:0] ACT_BRIGHT = 3'd3;
    localparam logic [2:0] ACT_EMIT   = 3'd4;

    localparam logic [1:0] SCOPE_ONE   = 2'd0;
    localparam logic [1:0] SCOPE_RANGE = 2'd1;
    localparam logic [1:0] SCOPE_ALL   = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FRAME  = 2'd2;

    localparam logic [1:0] REG_TABLE  = 2'd0;
    localparam logic [1:0] REG_LEVELS = 2'd1;
    localparam logic [1:0] REG_COUNTS = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] scope;
        logic [1:0] chip_sel;
        logic [4:0] led_index;
        logic [4:0] range_start;
        logic [4:0] range_end;
        logic [1:0] color_red;
        logic [1:0] color_green;
        logic [1:0] color_blue;
        logic [2:0] level_value;
        logic [7:0] brightness_value;
        logic       update_output;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] out_led_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last;
    } res_t;

    // one led's stored record
    typedef struct packed {
        logic [5:0]  color;
        logic [2:0]  level;
        logic [7:0]  bright;
        logic [23:0] outw;
    } led_rec_t;

    function automatic logic [7:0] chan_byte(input logic [7:0] b, input logic [1:0] lvl);
        logic [7:0] r;
        begin
            case (lvl)
                2'd2:    r = b;
                2'd1:    r = {1'b0, b[7:1]};
                default: r = 8'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/rlfs_cmd_if.sv =====
interface rlfs_cmd_if;
    import rlfs_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rlfs_res_if.sv =====
interface rlfs_res_if;
    import rlfs_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rlfs_led_ram.sv =====
module rlfs_led_ram
    import rlfs_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  led_rec_t          wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output led_rec_t          rd_data
);

    led_rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/rgb_led_frame_store.sv =====
// results: a rejected or set-range command gives only its status; a set command first walks
//   its leds through the led memory, then gives its status; an emit gives one frame item per led
// throughput: one led per cycle through the led memory while the result port does not stall;
//   a new command is taken only after the last result of the one before has transferred
// reset: a clearing pass writes all 128 led records to zero while no command is taken;
//   ranges and configuration registers reset at once
module rgb_led_frame_store
    import rlfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    rlfs_cmd_if.sink     cmd,
    rlfs_res_if.source   res
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_WALK  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [63:0] table_reg;
    logic [3:0]  levels_reg;
    logic [23:0] counts_reg;
    logic [4:0]  rfirst_reg [NUM_CHIPS];
    logic [4:0]  rlast_reg  [NUM_CHIPS];
    cmd_t        cmd_reg;
    logic [ADDR_W-1:0] clr_reg;
    // walk: current index, remaining count, and pipeline stage for read data
    logic [4:0]  idx_reg;
    logic [5:0]  left_reg;
    logic        rd_v_reg;
    logic [4:0]  rd_idx_reg;
    logic        rd_last_reg;
    logic        emit_reg;
    logic        out_v_reg;
    res_t        out_reg;
    logic [1:0]  final_st_reg;

    logic [5:0]  n_cnt;
    logic [3:0]  eff_lv;
    logic [7:0]  top;
    logic        ok;
    logic [5:0]  walk_len;
    logic [4:0]  walk_start;
    logic        ram_we, ram_re;
    logic [ADDR_W-1:0] wa, ra;
    led_rec_t    wd, rd;
    logic [7:0]  b_new, b_cl;
    logic [5:0]  c_new;
    logic [2:0]  l_new;
    logic [4:0]  s_r, e_r;
    logic        stall;

    rlfs_led_ram u_ram (
        .clk(clk), .wr_en(ram_we), .wr_addr(wa), .wr_data(wd),
        .rd_en(ram_re), .rd_addr(ra), .rd_data(rd)
    );

    always_comb
    begin
        n_cnt = counts_reg[cmd_reg.chip_sel*6 +: 6];
        if (n_cnt > 6'(MAX_LEDS)) n_cnt = 6'(MAX_LEDS);
        eff_lv = (levels_reg == 4'd0) ? 4'd1 : levels_reg;
        if (eff_lv > 4'(MAX_LEVELS)) eff_lv = 4'(MAX_LEVELS);
        top = table_reg[(eff_lv - 4'd1)*8 +: 8];
        s_r = rfirst_reg[cmd_reg.chip_sel];
        e_r = rlast_reg[cmd_reg.chip_sel];
        ok = (n_cnt != 6'd0) && (cmd_reg.action <= ACT_EMIT);
        walk_start = 5'd0;
        walk_len = 6'd0;
        if (ok)
        begin
            case (cmd_reg.action)
                ACT_RANGE:
                    ok = ({1'b0, cmd_reg.range_start} < n_cnt)
                      && ({1'b0, cmd_reg.range_end} < n_cnt);
                ACT_EMIT:
                    walk_len = n_cnt;
                default:
                begin
                    if (cmd_reg.action == ACT_LEVEL && {1'b0, cmd_reg.level_value} >= eff_lv)
                        ok = 1'b0;
                    else
                    begin
                        case (cmd_reg.scope)
                            SCOPE_ONE:
                            begin
                                ok = {1'b0, cmd_reg.led_index} < n_cnt;
                                walk_start = cmd_reg.led_index;
                                walk_len = 6'd1;
                            end
                            SCOPE_RANGE:
                            begin
                                ok = ({1'b0, s_r} < n_cnt) && ({1'b0, e_r} < n_cnt);
                                walk_start = s_r;
                                walk_len = (s_r <= e_r) ? 6'({1'b0, e_r} - {1'b0, s_r} + 6'd1)
                                         : 6'(n_cnt - {1'b0, s_r} + {1'b0, e_r} + 6'd1);
                            end
                            SCOPE_ALL:
                                walk_len = n_cnt;
                            default:
                                ok = 1'b0;
                        endcase
                    end
                end
            endcase
        end
    end

    // modify stage: data of the led read last cycle
    always_comb
    begin
        c_new = rd.color;
        l_new = rd.level;
        b_new = rd.bright;
        case (cmd_reg.action)
            ACT_COLOR:  c_new = {cmd_reg.color_blue, cmd_reg.color_green, cmd_reg.color_red};
            ACT_LEVEL:
            begin
                l_new = cmd_reg.level_value;
                b_new = table_reg[cmd_reg.level_value*8 +: 8];
            end
            default:    b_new = cmd_reg.brightness_value;
        endcase
        b_cl = (b_new > top) ? top : b_new;
        wd.color = c_new;
        wd.level = l_new;
        wd.bright = b_new;
        wd.outw = cmd_reg.update_output
                ? {chan_byte(b_cl, c_new[5:4]), chan_byte(b_cl, c_new[3:2]),
                   chan_byte(b_cl, c_new[1:0])}
                : rd.outw;
        if (state_reg == S_CLEAR)
            wd = '0;
    end

    assign stall = out_v_reg && !res.ready;
    assign ram_re = (state_reg == S_WALK) && !stall && (left_reg != 6'd0);
    assign ra = ADDR_W'({cmd_reg.chip_sel, idx_reg});
    assign ram_we = (state_reg == S_CLEAR) || (rd_v_reg && !emit_reg);
    assign wa = (state_reg == S_CLEAR) ? clr_reg
              : ADDR_W'({cmd_reg.chip_sel, rd_idx_reg});

    assign cmd.ready = (state_reg == S_IDLE) && !out_v_reg;
    assign res.valid = out_v_reg;
    assign res.data = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (cmd.valid && cmd.ready) state_next = S_READ;
            S_READ:  state_next = (ok && walk_len != 6'd0) ? S_WALK : S_OUT;
            S_WALK:  if (left_reg == 6'd0 && !stall) state_next = S_DRAIN;
            S_DRAIN: if (!stall) state_next = emit_reg ? S_IDLE : S_OUT;
            S_OUT:   if (!out_v_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            table_reg <= '0;
            levels_reg <= 4'd8;
            counts_reg <= '0;
            for (int i = 0; i < NUM_CHIPS; i++)
            begin
                rfirst_reg[i] <= '0;
                rlast_reg[i] <= '0;
            end
            clr_reg <= '0;
            out_v_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            left_reg <= '0;
            emit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TABLE:  table_reg <= cfg_data;
                    REG_LEVELS: levels_reg <= cfg_data[3:0];
                    REG_COUNTS: counts_reg <= cfg_data[23:0];
                    default:    ;
                endcase
            end
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            // a frame item loaded below replaces the one that transfers now
            if (out_v_reg && res.ready && !(rd_v_reg && emit_reg))
                out_v_reg <= 1'b0;
            if (!stall)
                rd_v_reg <= ram_re;
            case (state_reg)
                S_READ:
                begin
                    idx_reg <= walk_start;
                    left_reg <= walk_len;
                    emit_reg <= ok && cmd_reg.action == ACT_EMIT;
                    final_st_reg <= ok ? ST_DONE : ST_REJECT;
                    if (ok && cmd_reg.action == ACT_RANGE)
                    begin
                        rfirst_reg[cmd_reg.chip_sel] <= cmd_reg.range_start;
                        rlast_reg[cmd_reg.chip_sel] <= cmd_reg.range_end;
                    end
                end
                S_WALK:
                    if (ram_re)
                    begin
                        rd_idx_reg <= idx_reg;
                        rd_last_reg <= left_reg == 6'd1;
                        left_reg <= left_reg - 6'd1;
                        idx_reg <= ({1'b0, idx_reg} + 6'd1 >= n_cnt) ? 5'd0 : idx_reg + 5'd1;
                    end
                S_OUT:
                    if (!out_v_reg)
                    begin
                        out_v_reg <= 1'b1;
                        out_reg <= '{status: final_st_reg, out_led_index: 5'd0,
                                     red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                                     last: 1'b1};
                    end
                default: ;
            endcase
            if (rd_v_reg && emit_reg && !stall)
            begin
                out_v_reg <= 1'b1;
                out_reg <= '{status: ST_FRAME, out_led_index: rd_idx_reg,
                             red_out: rd.outw[7:0], green_out: rd.outw[15:8],
                             blue_out: rd.outw[23:16], last: rd_last_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            cmd_reg <= cmd.data;
    end

endmodule

// ===== test/rgb_led_frame_store_tb.sv =====
`timescale 1ns / 1ps

module rgb_led_frame_store_tb;
    import rlfs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    rlfs_cmd_if cmd ();
    rlfs_res_if res ();

    rgb_led_frame_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd.sink),
        .res       (res.source)
    );

    // shadow of the block's registers and led memory
    logic [63:0] tbl_shadow;
    logic [3:0]  levels_shadow;
    logic [23:0] counts_shadow;
    logic [5:0]  color_mem  [DEPTH];
    logic [7:0]  bright_mem [DEPTH];
    logic [23:0] out_mem    [DEPTH];
    logic [4:0]  first_mem  [NUM_CHIPS];
    logic [4:0]  last_mem   [NUM_CHIPS];

    res_t expected_q[$];
    int   errors;
    bit   sink_hold;
    bit   no_idle;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int usable_levels();
        int n;
        n = int'(levels_shadow);
        if (n == 0) n = 1;
        if (n > MAX_LEVELS) n = MAX_LEVELS;
        return n;
    endfunction

    function automatic int leds_on_chip(input logic [1:0] chip);
        int n;
        n = int'((counts_shadow >> (chip * CNT_W)) & 24'h3f);
        if (n > MAX_LEDS) n = MAX_LEDS;
        return n;
    endfunction

    function automatic logic [7:0] level_byte(input logic [7:0] b, input logic [1:0] lvl);
        if (lvl == 2'd2) return b;
        if (lvl == 2'd1) return b >> 1;
        return 8'd0;
    endfunction

    function automatic void recompose(input int slot);
        logic [7:0] top;
        logic [7:0] b;
        logic [5:0] c;
        top = tbl_shadow[(usable_levels() - 1) * 8 +: 8];
        b = bright_mem[slot];
        c = color_mem[slot];
        if (b > top) b = top;
        out_mem[slot] = {level_byte(b, c[5:4]), level_byte(b, c[3:2]), level_byte(b, c[1:0])};
    endfunction

    function automatic void touch_led(input cmd_t c, input int slot);
        if (c.action == ACT_COLOR)
            color_mem[slot] = {c.color_blue, c.color_green, c.color_red};
        else if (c.action == ACT_LEVEL)
            bright_mem[slot] = tbl_shadow[c.level_value * 8 +: 8];
        else
            bright_mem[slot] = c.brightness_value;
        if (c.update_output) recompose(slot);
    endfunction

    function automatic void push_status(input logic [1:0] st);
        res_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_command(input cmd_t c);
        int n;
        int base;
        int s;
        int e;
        res_t r;
        n = leds_on_chip(c.chip_sel);
        base = c.chip_sel * MAX_LEDS;
        if (n == 0 || c.action > ACT_EMIT)
        begin
            push_status(ST_REJECT);
            return;
        end
        if (c.action == ACT_RANGE)
        begin
            if (c.range_start >= n || c.range_end >= n) push_status(ST_REJECT);
            else
            begin
                first_mem[c.chip_sel] = c.range_start;
                last_mem[c.chip_sel] = c.range_end;
                push_status(ST_DONE);
            end
            return;
        end
        if (c.action == ACT_EMIT)
        begin
            for (int i = 0; i < n && i < MAX_RESULTS; i++)
            begin
                r.status = ST_FRAME;
                r.out_led_index = 5'(i);
                r.red_out = out_mem[base + i][7:0];
                r.green_out = out_mem[base + i][15:8];
                r.blue_out = out_mem[base + i][23:16];
                r.last = (i + 1 == n || i + 1 == MAX_RESULTS);
                expected_q.push_back(r);
            end
            return;
        end
        if (c.action == ACT_LEVEL && c.level_value >= usable_levels())
        begin
            push_status(ST_REJECT);
            return;
        end
        if (c.scope == SCOPE_ONE)
        begin
            if (c.led_index >= n)
            begin
                push_status(ST_REJECT);
                return;
            end
            touch_led(c, base + int'(c.led_index));
        end
        else if (c.scope == SCOPE_RANGE)
        begin
            s = int'(first_mem[c.chip_sel]);
            e = int'(last_mem[c.chip_sel]);
            if (s >= n || e >= n)
            begin
                push_status(ST_REJECT);
                return;
            end
            if (s <= e)
            begin
                for (int i = s; i <= e; i++) touch_led(c, base + i);
            end
            else
            begin
                for (int i = s; i < n; i++) touch_led(c, base + i);
                for (int i = 0; i <= e; i++) touch_led(c, base + i);
            end
        end
        else if (c.scope == SCOPE_ALL)
        begin
            for (int i = 0; i < n; i++) touch_led(c, base + i);
        end
        else
        begin
            push_status(ST_REJECT);
            return;
        end
        push_status(ST_DONE);
    endfunction

    // valid stays high after a transfer so items can follow back to back
    task automatic send_command(input cmd_t c);
        while (!no_idle && $urandom_range(99) < 6)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data <= c;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        predict_command(c);
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TABLE) tbl_shadow = val;
        else if (idx == REG_LEVELS) levels_shadow = val[3:0];
        else counts_shadow = val[23:0];
        @(posedge clk);
    endtask

    function automatic cmd_t random_command();
        cmd_t c;
        c = cmd_t'(40'({$urandom, $urandom}));
        c.action = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        if ($urandom_range(9) != 0) c.scope = 2'($urandom_range(2));
        if ($urandom_range(3) != 0)
        begin
            c.led_index = 5'($urandom_range(15));
            c.range_start = 5'($urandom_range(15));
            c.range_end = 5'($urandom_range(15));
        end
        return c;
    endfunction

    // sink side: random stalls, plus the long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n) res.ready <= 1'b0;
        else res.ready <= !sink_hold && (no_idle || $urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t expected nothing actual %p", $time, res.data);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (res.data !== want)
                begin
                    $display("%0t expected %p actual %p", $time, want, res.data);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        cmd_t c;
        write_reg(REG_TABLE, 64'hff_e0_80_40_20_10_08_01);
        write_reg(REG_LEVELS, 64'd8);
        // chip 0: 32 leds, chip 1: 5 leds, chip 2 absent, chip 3: 63 saturates
        write_reg(REG_COUNTS, 64'({6'd63, 6'd0, 6'd5, 6'd32}));
        c = '0;
        c.action = ACT_EMIT;
        send_command(c);
        c.action = ACT_RANGE; c.range_start = 5'd30; c.range_end = 5'd2;
        send_command(c);
        c.action = ACT_COLOR; c.scope = SCOPE_RANGE; c.color_red = 2'd2;
        c.color_green = 2'd1; c.color_blue = 2'd3; c.update_output = 1'b1;
        send_command(c);
        c.action = ACT_BRIGHT; c.scope = SCOPE_ALL; c.brightness_value = 8'hff;
        send_command(c);
        c.action = ACT_LEVEL; c.scope = SCOPE_ONE; c.led_index = 5'd31; c.level_value = 3'd7;
        send_command(c);
        c.action = ACT_BRIGHT; c.led_index = 5'd1; c.brightness_value = 8'h00;
        send_command(c);
        c.chip_sel = 2'd1; c.led_index = 5'd5;
        send_command(c);
        c.action = ACT_RANGE; c.range_start = 5'd0; c.range_end = 5'd31;
        send_command(c);
        c.action = ACT_COLOR; c.scope = SCOPE_RANGE;
        send_command(c);
        c.chip_sel = 2'd2; c.action = ACT_EMIT;
        send_command(c);
        c.chip_sel = 2'd0; c.scope = 2'd3; c.action = ACT_COLOR;
        send_command(c);
        c.action = 3'd7;
        send_command(c);
        c.action = ACT_EMIT;
        send_command(c);
        c.chip_sel = 2'd3;
        send_command(c);
        wait_drained();
        write_reg(REG_LEVELS, 64'd0);
        c = '0; c.action = ACT_LEVEL; c.scope = SCOPE_ALL; c.level_value = 3'd1;
        send_command(c);
        c.level_value = 3'd0; c.update_output = 1'b1;
        send_command(c);
        c.action = ACT_EMIT;
        send_command(c);
        wait_drained();
        write_reg(REG_LEVELS, 64'd15);
        write_reg(REG_TABLE, 64'h0);
        c.action = ACT_COLOR; c.color_red = 2'd2;
        send_command(c);
        c.action = ACT_EMIT;
        send_command(c);
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_TABLE, {$urandom, $urandom});
            write_reg(REG_LEVELS, 64'($urandom_range(15)));
            write_reg(REG_COUNTS, 64'({6'($urandom_range(63)), 6'($urandom_range(8)),
                                       6'($urandom_range(1, 12)), 6'($urandom_range(1, 6))}));
            no_idle = (phase == 2);
            for (int k = 0; k < 30; k++) send_command(random_command());
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        cmd_t c;
        fork
            begin
                sink_hold = 1'b1;
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
            end
            begin
                for (int k = 0; k < 20; k++)
                begin
                    c = random_command();
                    c.chip_sel = 2'd0;
                    send_command(c);
                end
            end
        join
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        sink_hold = 1'b0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.data = '0;
        tbl_shadow = '0;
        levels_shadow = 4'd8;
        counts_shadow = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            color_mem[i] = '0;
            bright_mem[i] = '0;
            out_mem[i] = '0;
        end
        for (int i = 0; i < NUM_CHIPS; i++)
        begin
            first_mem[i] = '0;
            last_mem[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        if (errors == 0)
            $display("rgb_led_frame_store: match");
        else
            $display("rgb_led_frame_store: mismatch");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("rgb_led_frame_store: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rlfs_pkg.sv
rtl/core/rlfs_cmd_if.sv
rtl/core/rlfs_res_if.sv
rtl/core/rlfs_led_ram.sv
rtl/core/rgb_led_frame_store.sv
test/rgb_led_frame_store_tb.sv
